// ===== hw/rtl/rfhw_pkg.sv =====
// Shared types, constants and the pointer wrap table of the ring FIFO.
package rfhw_pkg;

    // Storage geometry.
    localparam int C_DEPTH      = 16;
    localparam int C_ENTRY_BITS = 32;
    localparam int C_IDX_BITS   = $clog2(C_DEPTH);
    localparam int C_CAP_BITS   = 5;
    localparam int C_TBL_SIZE   = C_DEPTH * C_DEPTH;

    // Operation codes of the action field.
    localparam logic C_ACT_PUSH = 1'b0;
    localparam logic C_ACT_POP  = 1'b1;

    typedef logic [C_IDX_BITS-1:0]   t_idx;
    typedef logic [C_CAP_BITS-1:0]   t_cap;
    typedef logic [C_ENTRY_BITS-1:0] t_entry;
    typedef logic [C_TBL_SIZE-1:0][C_IDX_BITS-1:0] t_wrap_tbl;

    // Slot access request from the pointer logic to the slot storage.
    typedef struct packed {
        logic we;
        logic re;
        t_idx widx;
        t_idx ridx;
    } t_slot_req;

    // Outcome of one word, registered at the output.
    typedef struct packed {
        logic ok;
        logic pop_ok;
        t_cap high_water;
    } t_step_res;

    // Entry {capacity - 1, index} holds (index + 1) modulo capacity.
    // Built by counting, so no divider is ever involved.
    function automatic t_wrap_tbl f_build_wrap();
        t_wrap_tbl tbl;
        int r;
        tbl = '0;
        for (int c = 1; c <= C_DEPTH; c++) begin
            r = 0;
            for (int v = 0; v < C_DEPTH; v++) begin
                r = r + 1;
                if (r == c) begin
                    r = 0;
                end
                tbl[(c - 1) * C_DEPTH + v] = C_IDX_BITS'(r);
            end
        end
        return tbl;
    endfunction

    localparam t_wrap_tbl C_WRAP_TBL = f_build_wrap();

endpackage

// ===== hw/rtl/rfhw_if.sv =====
// Valid/ready channel interfaces for the input and result words.
interface rfhw_in_if;
    logic                          valid;
    logic                          ready;
    logic                          action;
    logic [rfhw_pkg::C_ENTRY_BITS-1:0] data_in;

    modport source (output valid, output action, output data_in, input ready);
    modport sink   (input valid, input action, input data_in, output ready);
endinterface

interface rfhw_out_if;
    logic                          valid;
    logic                          ready;
    logic                          ok;
    logic [rfhw_pkg::C_ENTRY_BITS-1:0] data_out;
    logic [rfhw_pkg::C_CAP_BITS-1:0]   high_water;

    modport source (output valid, output ok, output data_out, output high_water,
                    input ready);
    modport sink   (input valid, input ok, input data_out, input high_water,
                    output ready);
endinterface

// ===== hw/rtl/rfhw_slots.sv =====
// Slot storage of the ring FIFO: one write port and one registered read port.
module rfhw_slots (
    input  logic                i_clk,
    input  rfhw_pkg::t_slot_req i_req,
    input  rfhw_pkg::t_entry    i_wdata,
    output rfhw_pkg::t_entry    o_rdata
);
    import rfhw_pkg::*;

    t_entry r_mem [C_DEPTH];
    t_entry r_rdata;

    // Write at the tail slot on an accepted push.
    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.widx] <= i_wdata;
        end
    end

    // Read the head slot on an accepted pop; held while the result waits.
    always_ff @(posedge i_clk) begin
        if (i_req.re) begin
            r_rdata <= r_mem[i_req.ridx];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/rfhw_ctrl.sv =====
// Pointer, full flag, high-water and capacity logic of the ring FIFO.
module rfhw_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_accept,
    input  logic                i_action,
    input  logic                i_cfg_we,
    input  rfhw_pkg::t_cap      i_cfg_data,
    output rfhw_pkg::t_slot_req o_req,
    output rfhw_pkg::t_step_res o_res
);
    import rfhw_pkg::*;

    localparam int C_OCC_BITS = C_CAP_BITS + 2;

    t_idx r_head, n_head;
    t_idx r_tail, n_tail;
    logic r_full, n_full;
    t_cap r_peak, n_peak;
    t_cap r_cap;

    t_cap                   cap_eff;
    t_idx                   cap_m1;
    t_idx                   tail_wrap;
    t_idx                   head_wrap;
    logic                   push_ok;
    logic                   pop_ok;
    logic signed [C_OCC_BITS-1:0] occ_s;
    t_cap                   occ;

    // Capacity register; out-of-range values are clamped where used.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= C_CAP_BITS'(C_DEPTH);
        end else if (i_cfg_we) begin
            r_cap <= i_cfg_data;
        end
    end

    // Effective capacity and wrapped pointer successors.
    always_comb begin
        if (r_cap == '0) begin
            cap_eff = C_CAP_BITS'(1);
        end else if (r_cap > C_CAP_BITS'(C_DEPTH)) begin
            cap_eff = C_CAP_BITS'(C_DEPTH);
        end else begin
            cap_eff = r_cap;
        end
        cap_m1    = C_IDX_BITS'(cap_eff - C_CAP_BITS'(1));
        tail_wrap = C_WRAP_TBL[{cap_m1, r_tail}];
        head_wrap = C_WRAP_TBL[{cap_m1, r_head}];
    end

    assign push_ok = i_accept && (i_action == C_ACT_PUSH) && !r_full;
    assign pop_ok  = i_accept && (i_action == C_ACT_POP) && ((r_head != r_tail) || r_full);

    // Occupancy after a push, clamped to the effective capacity.
    always_comb begin
        occ_s = $signed(C_OCC_BITS'(tail_wrap)) - $signed(C_OCC_BITS'(r_head));
        if (tail_wrap <= r_head) begin
            occ_s = occ_s + $signed(C_OCC_BITS'(cap_eff));
        end
        if (occ_s < 0) begin
            occ = '0;
        end else if (occ_s > $signed(C_OCC_BITS'(cap_eff))) begin
            occ = cap_eff;
        end else begin
            occ = C_CAP_BITS'(occ_s);
        end
    end

    // Next state for the accepted word.
    always_comb begin
        n_head = r_head;
        n_tail = r_tail;
        n_full = r_full;
        n_peak = r_peak;
        if (push_ok) begin
            n_tail = tail_wrap;
            if (occ > r_peak) begin
                n_peak = occ;
            end
            if (tail_wrap == r_head) begin
                n_full = 1'b1;
                n_peak = cap_eff;
            end
        end else if (pop_ok) begin
            n_head = head_wrap;
            n_full = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= '0;
            r_tail <= '0;
            r_full <= 1'b0;
            r_peak <= '0;
        end else begin
            r_head <= n_head;
            r_tail <= n_tail;
            r_full <= n_full;
            r_peak <= n_peak;
        end
    end

    assign o_req.we   = push_ok;
    assign o_req.re   = pop_ok;
    assign o_req.widx = r_tail;
    assign o_req.ridx = r_head;

    assign o_res.ok         = push_ok || pop_ok;
    assign o_res.pop_ok     = pop_ok;
    assign o_res.high_water = n_peak;

    // A full queue always has its pointers together.
    a_full_ptrs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_full |-> (r_head == r_tail))
        else $error("full flag set with head and tail apart");

    // A refused push leaves the pointers and the high-water mark alone.
    a_refused_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && (i_action == C_ACT_PUSH) && r_full)
        |=> ($stable(r_tail) && $stable(r_head) && $stable(r_peak) && r_full))
        else $error("refused push changed state");

    // An accepted pop always leaves the queue not full.
    a_pop_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop_ok |=> !r_full)
        else $error("full flag survived a pop");

endmodule

// ===== hw/rtl/ring_fifo_with_high_water.sv =====
// Top level of the ring FIFO with high-water mark. Each input word (push or
// pop) gives exactly one result word, through the output register, in the
// cycle after it is taken; a new word is accepted every cycle as long as
// the result register is empty or being drained, so the sustained rate is
// one word per clock, set by the single pass through the pointer logic and
// the one slot access of that word. Capacity (1 to 16 slots, 0 acts as 1,
// larger values as 16) is written through the configuration port; the user
// must do so only while no word is in flight, not enforced by the block. A
// pop returns the head entry or is refused when empty; a push is refused
// when full. The high-water mark reports the largest occupancy since reset.
module ring_fifo_with_high_water (
    input  logic                i_clk,
    input  logic                i_rst_n,
    rfhw_in_if.sink             i_in,
    rfhw_out_if.source          o_out,
    input  logic                i_cfg_we,
    input  rfhw_pkg::t_cap      i_cfg_data
);
    import rfhw_pkg::*;

    logic      accept;
    t_slot_req slot_req;
    t_step_res step_res;
    t_entry    rdata;

    logic r_valid;
    logic r_ok;
    logic r_pop_ok;
    t_cap r_hw;

    // A word enters whenever the result register is free or being taken.
    assign i_in.ready = !r_valid || o_out.ready;
    assign accept     = i_in.valid && i_in.ready;

    rfhw_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (accept),
        .i_action   (i_in.action),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .o_req      (slot_req),
        .o_res      (step_res)
    );

    rfhw_slots u_slots (
        .i_clk   (i_clk),
        .i_req   (slot_req),
        .i_wdata (i_in.data_in),
        .o_rdata (rdata)
    );

    // Result register valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_valid <= 1'b0;
        end
    end

    // Result payload, loaded with each accepted word.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_ok     <= step_res.ok;
            r_pop_ok <= step_res.pop_ok;
            r_hw     <= step_res.high_water;
        end
    end

    assign o_out.valid      = r_valid;
    assign o_out.ok         = r_ok;
    assign o_out.data_out   = r_pop_ok ? rdata : '0;
    assign o_out.high_water = r_hw;

    // Every accepted word shows up as a result in the next cycle.
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_valid)
        else $error("accepted word produced no result");

endmodule

// ===== sim/ring_fifo_with_high_water_test.sv =====
// Self-checking test of the ring FIFO with high-water mark: directed and random push/pop words.
module ring_fifo_with_high_water_test;
    timeunit 1ns;
    timeprecision 1ps;

    import rfhw_pkg::*;

    // One result word as the block should deliver it.
    typedef struct {
        logic   ok;
        t_entry data;
        t_cap   high_water;
    } t_fifo_result;

    localparam int SETTLE_CYCLES = 4;
    localparam int REPORT_LIMIT  = 10;

    logic   clk;
    logic   rst_n;
    logic   cfg_we;
    t_cap   cfg_data;

    rfhw_in_if  in_ch ();
    rfhw_out_if out_ch ();

    ring_fifo_with_high_water dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in       (in_ch.sink),
        .o_out      (out_ch.source),
        .i_cfg_we   (cfg_we),
        .i_cfg_data (cfg_data)
    );

    // Shadow copy of the queue: slots, pointers, full flag, peak and capacity register.
    t_entry shadow_slots [C_DEPTH];
    int     head_pos;
    int     tail_pos;
    bit     shadow_full;
    int     peak_fill;
    t_cap   cap_reg;

    t_fifo_result pending_results [$];

    bit jitter_on;
    int error_count;
    int words_sent;
    int results_checked;
    int pushes_refused;
    int pops_refused;
    int full_hits;
    int cap_settings;

    // Clock generation.
    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Hard stop in case the block hangs.
    initial begin
        #2_000_000;
        $display("ring_fifo_with_high_water test failed");
        $finish;
    end

    // Number of slots the current capacity register really selects.
    function automatic int usable_slots();
        if (cap_reg == '0) begin
            return 1;
        end
        if (int'(cap_reg) > C_DEPTH) begin
            return C_DEPTH;
        end
        return int'(cap_reg);
    endfunction

    // Apply one accepted word to the shadow queue and queue the result it should give.
    task automatic predict_word(input logic act, input t_entry data);
        t_fifo_result res;
        int span;
        int fill;
        span = usable_slots();
        res.ok = 1'b0;
        res.data = '0;
        if (act == C_ACT_PUSH) begin
            if (!shadow_full) begin
                shadow_slots[tail_pos] = data;
                tail_pos = (tail_pos + 1) % span;
                fill = tail_pos - head_pos;
                if (tail_pos <= head_pos) begin
                    fill += span;
                end
                if (fill < 0) begin
                    fill = 0;
                end
                if (fill > span) begin
                    fill = span;
                end
                if (fill > peak_fill) begin
                    peak_fill = fill;
                end
                // Tail caught up with head: the queue is full and the peak is the capacity.
                if (tail_pos == head_pos) begin
                    shadow_full = 1'b1;
                    peak_fill = span;
                    full_hits++;
                end
                res.ok = 1'b1;
            end else begin
                pushes_refused++;
            end
        end else begin
            if (head_pos != tail_pos || shadow_full) begin
                res.data = shadow_slots[head_pos];
                head_pos = (head_pos + 1) % span;
                shadow_full = 1'b0;
                res.ok = 1'b1;
            end else begin
                pops_refused++;
            end
        end
        res.high_water = t_cap'(peak_fill);
        pending_results.push_back(res);
        words_sent++;
    endtask

    // Offer one word and hold it until the block takes it.
    task automatic send_word(input logic act, input t_entry data);
        if (jitter_on && $urandom_range(99) < 6) begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.action  <= act;
        in_ch.data_in <= data;
        @(posedge clk);
        while (!in_ch.ready) begin
            @(posedge clk);
        end
        predict_word(act, data);
    endtask

    // Stop sending until every outstanding result has come back, then let the block settle.
    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0) begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write the capacity register while the block is idle.
    task automatic set_capacity(input t_cap value);
        wait_drained();
        cfg_we   <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        cap_reg = value;
        cap_settings++;
    endtask

    // Fill all sixteen slots at reset capacity with six extreme patterns and then random data, then push once more.
    // Every slot is written here, so no later pop can read an unwritten slot.
    task automatic test_fill_to_full();
        t_entry patterns [6];
        patterns = '{32'h0000_0000, 32'hFFFF_FFFF, 32'hAAAA_AAAA,
                     32'h5555_5555, 32'h0000_0001, 32'h8000_0000};
        for (int i = 0; i < C_DEPTH; i++) begin
            send_word(C_ACT_PUSH, (i < 6) ? patterns[i] : t_entry'($urandom));
        end
        send_word(C_ACT_PUSH, 32'hDEAD_BEEF);
    endtask

    // Shrink capacity to zero (acts as one) with entries still queued, then
    // exercise refused pop, full at one slot and refused push.
    task automatic test_capacity_shrink_under_load();
        send_word(C_ACT_POP, $urandom);
        send_word(C_ACT_POP, $urandom);
        set_capacity(t_cap'(0));
        send_word(C_ACT_POP, $urandom);
        send_word(C_ACT_POP, $urandom);
        send_word(C_ACT_PUSH, 32'hFFFF_FFFF);
        send_word(C_ACT_PUSH, 32'h1234_5678);
        send_word(C_ACT_POP, $urandom);
    endtask

    // Random traffic at one capacity: push-heavy first to reach full, pop-heavy after to drain.
    task automatic test_random_traffic(input t_cap value, input int words, input bit hold_midway);
        int   push_odds;
        logic act;
        set_capacity(value);
        for (int i = 0; i < words; i++) begin
            push_odds = (i < words / 2) ? 75 : 25;
            if (hold_midway && i == words / 2) begin
                wait_drained();
            end
            act = ($urandom_range(99) < push_odds) ? C_ACT_PUSH : C_ACT_POP;
            send_word(act, $urandom);
        end
    endtask

    // Same traffic with neither side ever idling.
    task automatic test_back_to_back(input t_cap value, input int words);
        jitter_on = 1'b0;
        test_random_traffic(value, words, 1'b0);
        jitter_on = 1'b1;
    endtask

    // Compare each delivered result with the oldest expectation and drive ready.
    initial begin : result_checker
        t_fifo_result want;
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (rst_n && out_ch.valid && out_ch.ready) begin
                results_checked++;
                if (pending_results.size() == 0) begin
                    error_count++;
                    if (error_count <= REPORT_LIMIT) begin
                        $display("Unexpected result word: ok=%0b data=%h high_water=%0d",
                                 out_ch.ok, out_ch.data_out, out_ch.high_water);
                    end
                end else begin
                    want = pending_results.pop_front();
                    if (out_ch.ok !== want.ok || out_ch.data_out !== want.data ||
                        out_ch.high_water !== want.high_water) begin
                        error_count++;
                        if (error_count <= REPORT_LIMIT) begin
                            $display("Result %0d: expected %0b/%h/%0d, got %0b/%h/%0d",
                                     results_checked, want.ok, want.data, want.high_water,
                                     out_ch.ok, out_ch.data_out, out_ch.high_water);
                        end
                    end
                end
            end
            out_ch.ready <= rst_n && !(jitter_on && $urandom_range(99) < 6);
        end
    end

    // Test sequence.
    initial begin
        in_ch.valid   <= 1'b0;
        in_ch.action  <= C_ACT_PUSH;
        in_ch.data_in <= '0;
        cfg_we        <= 1'b0;
        cfg_data      <= '0;
        rst_n         <= 1'b0;
        for (int i = 0; i < C_DEPTH; i++) begin
            shadow_slots[i] = '0;
        end
        head_pos = 0;
        tail_pos = 0;
        shadow_full = 1'b0;
        peak_fill = 0;
        cap_reg = t_cap'(C_DEPTH);
        jitter_on = 1'b1;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_fill_to_full();
        test_capacity_shrink_under_load();
        test_random_traffic(t_cap'(16), 100, 1'b0);
        test_random_traffic(t_cap'(1), 60, 1'b0);
        test_random_traffic(t_cap'(31), 120, 1'b1);
        test_random_traffic(t_cap'(2), 80, 1'b0);
        test_back_to_back(t_cap'(16), 150);
        test_random_traffic(t_cap'(0), 60, 1'b0);
        test_random_traffic(t_cap'(7), 100, 1'b0);
        test_random_traffic(t_cap'(3), 80, 1'b0);
        test_random_traffic(t_cap'(12), 100, 1'b0);
        test_random_traffic(t_cap'($urandom_range(31)), 100, 1'b0);
        test_random_traffic(t_cap'(5), 50, 1'b0);

        wait_drained();
        $display("Sent %0d push/pop words over %0d capacity writes; the queue filled %0d times.",
                 words_sent, cap_settings, full_hits);
        $display("Refused %0d pushes on full and %0d pops on empty; %0d errors.",
                 pushes_refused, pops_refused, error_count);
        if (error_count == 0) begin
            $display("ring_fifo_with_high_water test passed");
        end else begin
            $display("ring_fifo_with_high_water test failed");
        end
        $finish;
    end

endmodule
